FILE: hdl/rfbsmp_pkg.sv
// Shared types, codes and constants of the RFB server message parser.
package rfbsmp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_VERSION  = 4'd1,
        PH_SECURITY = 4'd2,
        PH_CINIT    = 4'd3,
        PH_CMD      = 4'd4,
        PH_DATA     = 4'd5,
        PH_ENCLIST  = 4'd6,
        PH_SKIP     = 4'd7,
        PH_DONE     = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        EV_VERSION  = 3'd0,
        EV_SECTYPES = 3'd1,
        EV_SECOK    = 3'd2,
        EV_SECFAIL  = 3'd3,
        EV_SINIT    = 3'd4,
        EV_UPDATE   = 3'd5,
        EV_TERM     = 3'd6
    } t_event;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // client message types
    localparam logic [7:0] CMD_SET_PIX_FMT = 8'd0;
    localparam logic [7:0] CMD_SET_ENC     = 8'd2;
    localparam logic [7:0] CMD_UPDATE_REQ  = 8'd3;
    localparam logic [7:0] CMD_KEY         = 8'd4;
    localparam logic [7:0] CMD_POINTER     = 8'd5;
    localparam logic [7:0] CMD_CUT_TEXT    = 8'd6;

    localparam logic [31:0] ENC_ZLIB = 32'd6;
    localparam logic [31:0] ENC_CONT = 32'hFFFF_FEC7;   // -313

    localparam logic [31:0] VERSION_LEN   = 32'd12;
    localparam logic [31:0] PREFIX_LEN    = 32'd3;
    localparam logic [31:0] ENC_WORD_LEN  = 32'd4;
    localparam logic [31:0] DEPTH_BYTE    = 32'd5;
    localparam logic [31:0] INC_BYTE      = 32'd1;
    localparam logic [7:0]  SEC_NONE      = 8'd1;
    localparam logic [7:0]  DEPTH_CLIENT0 = 8'd32;
    localparam logic [7:0]  DEPTH_SERVER  = 8'd24;

    // configuration registers
    localparam logic        CFG_WIDTH    = 1'b0;
    localparam logic        CFG_HEIGHT   = 1'b1;
    localparam logic [15:0] WIDTH_RESET  = 16'd640;
    localparam logic [15:0] HEIGHT_RESET = 16'd480;

    localparam int RES_FIFO_DEPTH = 4;

    typedef struct packed {
        t_event      event_res;
        logic        incremental;
        logic [15:0] rect_x;
        logic [15:0] rect_y;
        logic [15:0] rect_w;
        logic [15:0] rect_h;
        logic        out_of_bounds;
        logic [7:0]  pixel_depth;
        logic        use_zlib;
        logic        last;
    } t_result;

    // up to two result words produced by one accepted item
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_res_push;

    // payload bytes following a command byte; zero marks an unknown command
    function automatic logic [4:0] f_data_length(logic [7:0] cmd);
        logic [4:0] len;
        unique case (cmd)
            CMD_SET_PIX_FMT: len = 5'd19;
            CMD_SET_ENC:     len = 5'd3;
            CMD_UPDATE_REQ:  len = 5'd9;
            CMD_KEY:         len = 5'd7;
            CMD_POINTER:     len = 5'd5;
            CMD_CUT_TEXT:    len = 5'd7;
            default:         len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] f_prefix_char(logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h52;  // R
            2'd1:    c = 8'h46;  // F
            2'd2:    c = 8'h42;  // B
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/rfbsmp_core.sv
// Protocol state and per-word decode of the RFB server message parser.
module rfbsmp_core
    import rfbsmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    output t_res_push   o_push
);

    t_phase      r_phase,        n_phase;
    logic [7:0]  r_command,      n_command;
    logic [31:0] r_byte_count,   n_byte_count;
    logic [63:0] r_param_shift,  n_param_shift;
    logic        r_version_ok,   n_version_ok;
    logic [15:0] r_enc_left,     n_enc_left;
    logic [31:0] r_enc_word,     n_enc_word;
    logic        r_pend_zlib,    n_pend_zlib;
    logic        r_pend_cont,    n_pend_cont;
    logic [7:0]  r_client_depth, n_client_depth;
    logic        r_zlib_on,      n_zlib_on;
    logic        r_cont_on,      n_cont_on;

    logic [31:0] byte_inc;
    logic [63:0] shifted;
    logic [31:0] enc_shifted;
    logic [4:0]  need;
    logic [15:0] enc_left_dec;
    logic        live_phase;

    function automatic t_result f_ctl(t_event ev, logic last);
        t_result r;
        r = '0;
        r.event_res = ev;
        r.last      = last;
        return r;
    endfunction

    function automatic t_result f_upd(logic inc, logic [15:0] x, logic [15:0] y,
                                      logic [15:0] w, logic [15:0] h, logic [7:0] dep,
                                      logic zl, logic [15:0] sw, logic [15:0] sh);
        t_result r;
        r = '0;
        r.event_res     = EV_UPDATE;
        r.incremental   = inc;
        r.rect_x        = x;
        r.rect_y        = y;
        r.rect_w        = w;
        r.rect_h        = h;
        r.out_of_bounds = (({1'b0, x} + {1'b0, w}) > {1'b0, sw}) ||
                          (({1'b0, y} + {1'b0, h}) > {1'b0, sh});
        r.pixel_depth   = dep;
        r.use_zlib      = zl;
        r.last          = 1'b1;
        return r;
    endfunction

    assign byte_inc     = r_byte_count + 32'd1;
    assign shifted      = {r_param_shift[55:0], i_rx_byte};
    assign enc_shifted  = {r_enc_word[23:0], i_rx_byte};
    assign need         = f_data_length(r_command);
    assign enc_left_dec = r_enc_left - 16'd1;
    assign live_phase   = (r_phase == PH_CMD) || (r_phase == PH_DATA) ||
                          (r_phase == PH_ENCLIST) || (r_phase == PH_SKIP);

    always_comb begin
        n_phase        = r_phase;
        n_command      = r_command;
        n_byte_count   = r_byte_count;
        n_param_shift  = r_param_shift;
        n_version_ok   = r_version_ok;
        n_enc_left     = r_enc_left;
        n_enc_word     = r_enc_word;
        n_pend_zlib    = r_pend_zlib;
        n_pend_cont    = r_pend_cont;
        n_client_depth = r_client_depth;
        n_zlib_on      = r_zlib_on;
        n_cont_on      = r_cont_on;
        o_push         = '0;

        if (i_take) begin
            unique case (t_action'(i_action))
                ACT_START: begin
                    n_phase        = PH_VERSION;
                    n_command      = '0;
                    n_byte_count   = '0;
                    n_param_shift  = '0;
                    n_version_ok   = 1'b1;
                    n_enc_left     = '0;
                    n_enc_word     = '0;
                    n_pend_zlib    = 1'b0;
                    n_pend_cont    = 1'b0;
                    n_client_depth = DEPTH_CLIENT0;
                    n_zlib_on      = 1'b0;
                    n_cont_on      = 1'b0;
                    o_push.count   = 2'd1;
                    o_push.first   = f_ctl(EV_VERSION, 1'b1);
                end
                ACT_TICK: begin
                    if (live_phase && r_cont_on) begin
                        o_push.count = 2'd1;
                        o_push.first = f_upd(1'b0, 16'd0, 16'd0, i_width, i_height,
                                             DEPTH_SERVER, r_zlib_on, i_width, i_height);
                    end
                end
                ACT_BYTE: begin
                    unique case (r_phase)
                        PH_VERSION: begin
                            if (r_byte_count < PREFIX_LEN &&
                                i_rx_byte != f_prefix_char(r_byte_count[1:0]))
                                n_version_ok = 1'b0;
                            n_byte_count = byte_inc;
                            if (byte_inc == VERSION_LEN) begin
                                n_byte_count = '0;
                                o_push.count = 2'd1;
                                if (n_version_ok) begin
                                    n_phase      = PH_SECURITY;
                                    o_push.first = f_ctl(EV_SECTYPES, 1'b1);
                                end else begin
                                    n_phase      = PH_DONE;
                                    o_push.first = f_ctl(EV_TERM, 1'b1);
                                end
                            end
                        end
                        PH_SECURITY: begin
                            if (i_rx_byte == SEC_NONE) begin
                                n_phase      = PH_CINIT;
                                o_push.count = 2'd1;
                                o_push.first = f_ctl(EV_SECOK, 1'b1);
                            end else begin
                                n_phase       = PH_DONE;
                                o_push.count  = 2'd2;
                                o_push.first  = f_ctl(EV_SECFAIL, 1'b0);
                                o_push.second = f_ctl(EV_TERM, 1'b1);
                            end
                        end
                        PH_CINIT: begin
                            n_phase                  = PH_CMD;
                            o_push.count             = 2'd1;
                            o_push.first             = f_ctl(EV_SINIT, 1'b1);
                            o_push.first.rect_w      = i_width;
                            o_push.first.rect_h      = i_height;
                            o_push.first.pixel_depth = DEPTH_SERVER;
                        end
                        PH_CMD: begin
                            n_command     = i_rx_byte;
                            n_byte_count  = '0;
                            n_param_shift = '0;
                            if (f_data_length(i_rx_byte) == 5'd0) begin
                                n_phase      = PH_DONE;
                                o_push.count = 2'd1;
                                o_push.first = f_ctl(EV_TERM, 1'b1);
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                        PH_DATA: begin
                            if (need == 5'd0) begin
                                n_phase      = PH_DONE;
                                o_push.count = 2'd1;
                                o_push.first = f_ctl(EV_TERM, 1'b1);
                            end else begin
                                n_param_shift = shifted;
                                n_byte_count  = byte_inc;
                                if (r_command == CMD_SET_PIX_FMT && byte_inc == DEPTH_BYTE)
                                    n_client_depth = i_rx_byte;
                                if (r_command == CMD_UPDATE_REQ && byte_inc == INC_BYTE)
                                    n_enc_word = {24'd0, i_rx_byte};
                                if (byte_inc >= {27'd0, need}) begin
                                    n_byte_count = '0;
                                    n_phase      = PH_CMD;
                                    if (r_command == CMD_SET_ENC) begin
                                        n_enc_left  = shifted[15:0];
                                        n_pend_zlib = 1'b0;
                                        n_pend_cont = 1'b0;
                                        n_enc_word  = '0;
                                        if (shifted[15:0] == 16'd0) begin
                                            // empty list commits both flags as clear
                                            n_zlib_on = 1'b0;
                                            n_cont_on = 1'b0;
                                        end else begin
                                            n_phase = PH_ENCLIST;
                                        end
                                    end else if (r_command == CMD_UPDATE_REQ) begin
                                        o_push.count = 2'd1;
                                        o_push.first = f_upd(n_enc_word != 32'd0,
                                                             shifted[63:48], shifted[47:32],
                                                             shifted[31:16], shifted[15:0],
                                                             r_client_depth, r_zlib_on,
                                                             i_width, i_height);
                                    end else if (r_command == CMD_CUT_TEXT) begin
                                        if (shifted[31:0] != 32'd0) begin
                                            n_byte_count = shifted[31:0];
                                            n_phase      = PH_SKIP;
                                        end
                                    end
                                end
                            end
                        end
                        PH_ENCLIST: begin
                            n_enc_word   = enc_shifted;
                            n_byte_count = byte_inc;
                            if (byte_inc == ENC_WORD_LEN) begin
                                n_byte_count = '0;
                                if (enc_shifted == ENC_ZLIB) n_pend_zlib = 1'b1;
                                if (enc_shifted == ENC_CONT) n_pend_cont = 1'b1;
                                n_enc_left = enc_left_dec;
                                if (enc_left_dec == 16'd0) begin
                                    n_zlib_on = n_pend_zlib;
                                    n_cont_on = n_pend_cont;
                                    n_phase   = PH_CMD;
                                end
                            end
                        end
                        PH_SKIP: begin
                            n_byte_count = r_byte_count - 32'd1;
                            if (r_byte_count == 32'd1) n_phase = PH_CMD;
                        end
                        default: ;
                    endcase
                end
                ACT_NONE: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_command      <= '0;
            r_byte_count   <= '0;
            r_param_shift  <= '0;
            r_version_ok   <= 1'b1;
            r_enc_left     <= '0;
            r_enc_word     <= '0;
            r_pend_zlib    <= 1'b0;
            r_pend_cont    <= 1'b0;
            r_client_depth <= DEPTH_CLIENT0;
            r_zlib_on      <= 1'b0;
            r_cont_on      <= 1'b0;
        end else begin
            r_phase        <= n_phase;
            r_command      <= n_command;
            r_byte_count   <= n_byte_count;
            r_param_shift  <= n_param_shift;
            r_version_ok   <= n_version_ok;
            r_enc_left     <= n_enc_left;
            r_enc_word     <= n_enc_word;
            r_pend_zlib    <= n_pend_zlib;
            r_pend_cont    <= n_pend_cont;
            r_client_depth <= n_client_depth;
            r_zlib_on      <= n_zlib_on;
            r_cont_on      <= n_cont_on;
        end
    end

    // a terminated session stays dead until the next session start
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE && !(i_take && i_action == ACT_START)) |=> r_phase == PH_DONE)
        else $error("terminated session left without session start");

    a_two_only_secfail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count == 2'd2) |->
            (r_phase == PH_SECURITY && i_action == ACT_BYTE && i_take))
        else $error("two result words outside security refusal");

    a_oob_update_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.count != 2'd0 && o_push.first.out_of_bounds) |->
            o_push.first.event_res == EV_UPDATE)
        else $error("out of bounds flagged on a non-update word");

endmodule

FILE: hdl/rfbsmp_fifo.sv
// Result queue taking up to two words per cycle, releasing one on i_ready.
module rfbsmp_fifo
    import rfbsmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_res_push i_push,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_ready,
    output t_result   o_data
);

    localparam int PTR_W = $clog2(RES_FIFO_DEPTH);
    localparam int CNT_W = $clog2(RES_FIFO_DEPTH + 1);

    t_result            r_mem [RES_FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wp, n_wp;
    logic [PTR_W-1:0]   r_rp, n_rp;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [PTR_W-1:0]   wp_next;
    logic               pop;

    assign pop     = o_valid && i_ready;
    assign wp_next = r_wp + PTR_W'(1);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    // room for a worst-case pair of words
    assign o_room  = (r_count <= CNT_W'(RES_FIFO_DEPTH - 2));

    always_comb begin
        n_wp    = r_wp + PTR_W'(i_push.count);
        n_rp    = pop ? r_rp + PTR_W'(1) : r_rp;
        n_count = r_count + CNT_W'(i_push.count) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) r_mem[r_wp]    <= i_push.first;
        if (i_push.count == 2'd2) r_mem[wp_next] <= i_push.second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_count} + {{(CNT_W - 1){1'b0}}, i_push.count}) <=
            (CNT_W + 1)'(RES_FIFO_DEPTH))
        else $error("result queue overflow");

endmodule

FILE: hdl/rfb_server_message_parser_top.sv
// Top level of the RFB server message parser: config registers, decoder, result queue.
//
// Input channel (i_valid/o_ready): one word per cycle carrying i_action (session start,
// client byte, frame tick) and i_rx_byte. Output channel (o_valid/i_ready): result words
// with an event code, update rectangle and encoding hints; o_last marks the final word
// produced by an input word. A refused security byte yields two words, everything else
// zero or one.
// A result word is registered in the queue when its input word is accepted.
// Throughput: one input word per cycle while o_ready is high; the protocol state
// updates in one pass of logic between the state registers. A four-word result queue
// decouples the sides; o_ready drops while fewer than two slots are free.
// Config: i_cfg_we writes screen width (index 0) or height (index 1) on the same edge.
// Reset (i_rst_n low, synchronous): waiting for session start, width 640, height 480,
// queue empty. If the receiver stalls the queue fills and o_ready falls; nothing is lost.
module rfb_server_message_parser_top
    import rfbsmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic        o_incremental,
    output logic [15:0] o_rect_x,
    output logic [15:0] o_rect_y,
    output logic [15:0] o_rect_w,
    output logic [15:0] o_rect_h,
    output logic        o_out_of_bounds,
    output logic [7:0]  o_pixel_depth,
    output logic        o_use_zlib,
    output logic        o_last
);

    logic [15:0] r_screen_width;
    logic [15:0] r_screen_height;
    t_res_push   push;
    t_result     res;
    logic        take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= WIDTH_RESET;
            r_screen_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIDTH)  r_screen_width  <= i_cfg_wdata;
            if (i_cfg_idx == CFG_HEIGHT) r_screen_height <= i_cfg_wdata;
        end
    end

    assign take = i_valid && o_ready;

    rfbsmp_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_action  (i_action),
        .i_rx_byte (i_rx_byte),
        .i_width   (r_screen_width),
        .i_height  (r_screen_height),
        .o_push    (push)
    );

    rfbsmp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (res)
    );

    assign o_event_res     = res.event_res;
    assign o_incremental   = res.incremental;
    assign o_rect_x        = res.rect_x;
    assign o_rect_y        = res.rect_y;
    assign o_rect_w        = res.rect_w;
    assign o_rect_h        = res.rect_h;
    assign o_out_of_bounds = res.out_of_bounds;
    assign o_pixel_depth   = res.pixel_depth;
    assign o_use_zlib      = res.use_zlib;
    assign o_last          = res.last;

endmodule

FILE: tb/sv/rfb_server_message_parser_top_tb.sv
// Self-checking testbench for the RFB server message parser top level.
module rfb_server_message_parser_top_tb;
    import rfbsmp_pkg::*;

    localparam int RUN_LIMIT     = 2_000_000;
    localparam int PHASE_WORDS   = 110;
    localparam int PHASE_REPLIES = 6;

    // Tracks the protocol state of one client session and the reply words it must produce.
    class rfb_reply_scoreboard;
        t_result     replies_due[$];
        int          errors;
        int          replies_made;
        logic [15:0] width;
        logic [15:0] height;
        t_phase      phase;
        logic [7:0]  command;
        logic [31:0] byte_count;
        logic [63:0] param_shift;
        bit          version_ok;
        logic [15:0] encodings_left;
        logic [31:0] enc_word;
        bit          pending_zlib;
        bit          pending_cont;
        logic [7:0]  client_depth;
        bit          zlib_on;
        bit          cont_on;

        function new();
            width        = WIDTH_RESET;
            height       = HEIGHT_RESET;
            errors       = 0;
            replies_made = 0;
            clear_session();
        endfunction

        function void clear_session();
            phase          = PH_IDLE;
            command        = 8'd0;
            byte_count     = 32'd0;
            param_shift    = 64'd0;
            version_ok     = 1'b1;
            encodings_left = 16'd0;
            enc_word       = 32'd0;
            pending_zlib   = 1'b0;
            pending_cont   = 1'b0;
            client_depth   = DEPTH_CLIENT0;
            zlib_on        = 1'b0;
            cont_on        = 1'b0;
        endfunction

        function void commit_encodings();
            zlib_on = pending_zlib;
            cont_on = pending_cont;
            phase   = PH_CMD;
        endfunction

        function logic [4:0] payload_len(logic [7:0] cmd);
            case (cmd)
                CMD_SET_PIX_FMT: return 5'd19;
                CMD_SET_ENC:     return 5'd3;
                CMD_UPDATE_REQ:  return 5'd9;
                CMD_KEY:         return 5'd7;
                CMD_POINTER:     return 5'd5;
                CMD_CUT_TEXT:    return 5'd7;
                default:         return 5'd0;
            endcase
        endfunction

        function void add_reply(t_event ev, bit inc, logic [15:0] x, logic [15:0] y,
                                logic [15:0] w, logic [15:0] h, logic [7:0] depth,
                                bit zl, bit last);
            t_result r;
            r.event_res     = ev;
            r.incremental   = inc;
            r.rect_x        = x;
            r.rect_y        = y;
            r.rect_w        = w;
            r.rect_h        = h;
            // 17-bit sums: the edge may lie past 65535
            r.out_of_bounds = (ev == EV_UPDATE) &&
                              (({1'b0, x} + w > width) || ({1'b0, y} + h > height));
            r.pixel_depth   = depth;
            r.use_zlib      = zl;
            r.last          = last;
            replies_due.insert(replies_due.size(), r);
            replies_made++;
        endfunction

        // Returns 1 when the word has any effect on the session.
        function bit note_word(t_action act, logic [7:0] b);
            logic [4:0] need;
            logic [7:0] want_char;
            case (act)
                ACT_START: begin
                    clear_session();
                    phase = PH_VERSION;
                    add_reply(EV_VERSION, 0, 0, 0, 0, 0, 0, 0, 1);
                    return 1'b1;
                end
                ACT_TICK: begin
                    if (phase >= PH_CMD && phase <= PH_SKIP && cont_on) begin
                        add_reply(EV_UPDATE, 0, 0, 0, width, height, DEPTH_SERVER, zlib_on, 1);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                ACT_BYTE: ;
                default: return 1'b0;
            endcase

            case (phase)
                PH_VERSION: begin
                    if (byte_count < PREFIX_LEN) begin
                        case (byte_count[1:0])
                            2'd0:    want_char = "R";
                            2'd1:    want_char = "F";
                            default: want_char = "B";
                        endcase
                        if (b != want_char)
                            version_ok = 1'b0;
                    end
                    byte_count++;
                    if (byte_count == VERSION_LEN) begin
                        byte_count = 32'd0;
                        if (version_ok) begin
                            phase = PH_SECURITY;
                            add_reply(EV_SECTYPES, 0, 0, 0, 0, 0, 0, 0, 1);
                        end else begin
                            phase = PH_DONE;
                            add_reply(EV_TERM, 0, 0, 0, 0, 0, 0, 0, 1);
                        end
                    end
                end
                PH_SECURITY: begin
                    if (b == SEC_NONE) begin
                        phase = PH_CINIT;
                        add_reply(EV_SECOK, 0, 0, 0, 0, 0, 0, 0, 1);
                    end else begin
                        phase = PH_DONE;
                        add_reply(EV_SECFAIL, 0, 0, 0, 0, 0, 0, 0, 0);
                        add_reply(EV_TERM, 0, 0, 0, 0, 0, 0, 0, 1);
                    end
                end
                PH_CINIT: begin
                    phase = PH_CMD;
                    add_reply(EV_SINIT, 0, 0, 0, width, height, DEPTH_SERVER, 0, 1);
                end
                PH_CMD: begin
                    command     = b;
                    byte_count  = 32'd0;
                    param_shift = 64'd0;
                    if (payload_len(b) == 5'd0) begin
                        phase = PH_DONE;
                        add_reply(EV_TERM, 0, 0, 0, 0, 0, 0, 0, 1);
                    end else begin
                        phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    need = payload_len(command);
                    if (need == 5'd0) begin
                        phase = PH_DONE;
                        add_reply(EV_TERM, 0, 0, 0, 0, 0, 0, 0, 1);
                    end else begin
                        param_shift = {param_shift[55:0], b};
                        byte_count++;
                        if (command == CMD_SET_PIX_FMT && byte_count == DEPTH_BYTE)
                            client_depth = b;
                        if (command == CMD_UPDATE_REQ && byte_count == INC_BYTE)
                            enc_word = {24'd0, b};
                        if (byte_count >= need) begin
                            byte_count = 32'd0;
                            phase      = PH_CMD;
                            case (command)
                                CMD_SET_ENC: begin
                                    encodings_left = param_shift[15:0];
                                    pending_zlib   = 1'b0;
                                    pending_cont   = 1'b0;
                                    enc_word       = 32'd0;
                                    if (encodings_left == 16'd0)
                                        commit_encodings();
                                    else
                                        phase = PH_ENCLIST;
                                end
                                CMD_UPDATE_REQ: begin
                                    add_reply(EV_UPDATE, enc_word != 32'd0,
                                              param_shift[63:48], param_shift[47:32],
                                              param_shift[31:16], param_shift[15:0],
                                              client_depth, zlib_on, 1);
                                end
                                CMD_CUT_TEXT: begin
                                    if (param_shift[31:0] != 32'd0) begin
                                        byte_count = param_shift[31:0];
                                        phase      = PH_SKIP;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                PH_ENCLIST: begin
                    enc_word = {enc_word[23:0], b};
                    byte_count++;
                    if (byte_count == ENC_WORD_LEN) begin
                        byte_count = 32'd0;
                        if (enc_word == ENC_ZLIB)
                            pending_zlib = 1'b1;
                        if (enc_word == ENC_CONT)
                            pending_cont = 1'b1;
                        encodings_left--;
                        if (encodings_left == 16'd0)
                            commit_encodings();
                    end
                end
                PH_SKIP: begin
                    byte_count--;
                    if (byte_count == 32'd0)
                        phase = PH_CMD;
                end
                default: return 1'b0;   // idle or terminated: byte dropped
            endcase
            return 1'b1;
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(t_result got);
            t_result want;
            if (replies_due.size() == 0) begin
                $error("event_res: expected no word, got %0d", got.event_res);
                errors++;
                return;
            end
            want = replies_due.pop_front();
            check_field("event_res", want.event_res, got.event_res);
            check_field("incremental", want.incremental, got.incremental);
            check_field("rect_x", want.rect_x, got.rect_x);
            check_field("rect_y", want.rect_y, got.rect_y);
            check_field("rect_w", want.rect_w, got.rect_w);
            check_field("rect_h", want.rect_h, got.rect_h);
            check_field("out_of_bounds", want.out_of_bounds, got.out_of_bounds);
            check_field("pixel_depth", want.pixel_depth, got.pixel_depth);
            check_field("use_zlib", want.use_zlib, got.use_zlib);
            check_field("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [15:0] i_cfg_wdata;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_action;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_event_res;
    logic        o_incremental;
    logic [15:0] o_rect_x;
    logic [15:0] o_rect_y;
    logic [15:0] o_rect_w;
    logic [15:0] o_rect_h;
    logic        o_out_of_bounds;
    logic [7:0]  o_pixel_depth;
    logic        o_use_zlib;
    logic        o_last;

    rfb_reply_scoreboard sb;
    t_result             seen_reply;
    bit                  no_idle;
    int                  phase_words;
    string               version_tag = "RFB 003.008\n";

    rfb_server_message_parser_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT);
        $display("rfb_server_message_parser_top verification failed");
        $finish;
    end

    always @(posedge i_clk)
        i_ready <= no_idle || ($urandom_range(0, 99) >= 29);

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid && i_ready) begin
            seen_reply.event_res     = t_event'(o_event_res);
            seen_reply.incremental   = o_incremental;
            seen_reply.rect_x        = o_rect_x;
            seen_reply.rect_y        = o_rect_y;
            seen_reply.rect_w        = o_rect_w;
            seen_reply.rect_h        = o_rect_h;
            seen_reply.out_of_bounds = o_out_of_bounds;
            seen_reply.pixel_depth   = o_pixel_depth;
            seen_reply.use_zlib      = o_use_zlib;
            seen_reply.last          = o_last;
            sb.check_reply(seen_reply);
        end
    end

    task automatic send_word(t_action act, logic [7:0] b);
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 29) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid   <= 1'b1;
        i_action  <= act;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        if (sb.note_word(act, b))
            phase_words++;
    endtask

    task automatic send_junk(int n);
        repeat (n) send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_u16(logic [15:0] v);
        send_word(ACT_BYTE, v[15:8]);
        send_word(ACT_BYTE, v[7:0]);
    endtask

    task automatic send_u32(logic [31:0] v);
        send_u16(v[31:16]);
        send_u16(v[15:0]);
    endtask

    // stray ticks, unused action codes and the odd misplaced byte
    task automatic maybe_noise();
        int r;
        r = $urandom_range(0, 99);
        if (r < 14)
            send_word(ACT_TICK, 8'($urandom_range(0, 255)));
        else if (r < 17)
            send_word(ACT_NONE, 8'($urandom_range(0, 255)));
        else if (r < 19)
            send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic open_session(bit corrupt, logic [7:0] sec);
        int         bad_at;
        bit         scramble;
        logic [7:0] c;
        bad_at   = corrupt ? $urandom_range(0, 2) : -1;
        scramble = $urandom_range(0, 1);
        send_word(ACT_START, 8'($urandom_range(0, 255)));
        for (int i = 0; i < int'(VERSION_LEN); i++) begin
            c = version_tag[i];
            if (i == bad_at)
                c = c ^ 8'($urandom_range(1, 255));
            else if (scramble && i >= int'(PREFIX_LEN))
                c = 8'($urandom_range(0, 255));
            send_word(ACT_BYTE, c);
        end
        maybe_noise();
        send_word(ACT_BYTE, sec);
        send_word(ACT_BYTE, 8'($urandom_range(0, 255)));   // ClientInit
    endtask

    function automatic logic [15:0] pick_span(logic [15:0] lim);
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, lim));
            3:       return lim >> 1;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic random_message();
        int          k;
        int          n;
        logic [15:0] cnt;
        logic [31:0] len;
        k = $urandom_range(0, 99);
        if (k < 14) begin
            send_word(ACT_BYTE, CMD_SET_PIX_FMT);
            send_junk(4);
            case ($urandom_range(0, 4))
                0:       send_word(ACT_BYTE, 8'd8);
                1:       send_word(ACT_BYTE, 8'd16);
                2:       send_word(ACT_BYTE, 8'd24);
                3:       send_word(ACT_BYTE, 8'd32);
                default: send_junk(1);
            endcase
            send_junk(14);
        end else if (k < 34) begin
            send_word(ACT_BYTE, CMD_SET_ENC);
            send_junk(1);
            cnt = ($urandom_range(0, 49) == 0) ? 16'($urandom_range(256, 65535))
                                               : 16'($urandom_range(0, 4));
            send_u16(cnt);
            // a huge list is left unfinished; the next session start recovers
            n = (cnt > 16'd4) ? $urandom_range(1, 3) : int'(cnt);
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0, 1:    send_u32(ENC_ZLIB);
                    2, 3:    send_u32(ENC_CONT);
                    4:       send_u32(ENC_CONT ^ (32'd1 << $urandom_range(0, 31)));
                    default: send_u32($urandom);
                endcase
            end
        end else if (k < 60) begin
            send_word(ACT_BYTE, CMD_UPDATE_REQ);
            case ($urandom_range(0, 2))
                0:       send_word(ACT_BYTE, 8'd0);
                1:       send_word(ACT_BYTE, 8'd1);
                default: send_junk(1);
            endcase
            send_u16(pick_span(sb.width));
            send_u16(pick_span(sb.height));
            send_u16(pick_span(sb.width));
            send_u16(pick_span(sb.height));
        end else if (k < 70) begin
            send_word(ACT_BYTE, CMD_KEY);
            send_junk(7);
        end else if (k < 80) begin
            send_word(ACT_BYTE, CMD_POINTER);
            send_junk(5);
        end else if (k < 93) begin
            send_word(ACT_BYTE, CMD_CUT_TEXT);
            send_junk(3);
            len = ($urandom_range(0, 39) == 0) ? ($urandom | 32'h0001_0000)
                                               : 32'($urandom_range(0, 6));
            send_u32(len);
            if (len <= 32'd6)
                send_junk(int'(len));
        end else begin
            send_word(ACT_BYTE, $urandom_range(0, 1) ? 8'($urandom_range(7, 255)) : 8'd1);
        end
    endtask

    task automatic run_session();
        int n;
        open_session($urandom_range(0, 99) < 6,
                     ($urandom_range(0, 99) < 7) ? 8'($urandom_range(0, 255)) : SEC_NONE);
        n = $urandom_range(3, 14);
        repeat (n) begin
            if (sb.phase == PH_DONE)
                break;
            random_message();
            maybe_noise();
        end
        if (sb.phase == PH_DONE)
            send_word(ACT_BYTE, 8'($urandom_range(0, 255)));
    endtask

    // drain the reply queue, then leave the pipeline time to empty
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_screen(logic [15:0] w, logic [15:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        sb.width     = w;
        i_cfg_idx   <= CFG_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        sb.height    = h;
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [15:0] w;
        logic [15:0] h;
        int          replies_at_start;
        sb          = new();
        no_idle     = 1'b0;
        phase_words = 0;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= CFG_WIDTH;
        i_cfg_wdata <= 16'd0;
        i_valid     <= 1'b0;
        i_action    <= ACT_NONE;
        i_rx_byte   <= 8'd0;
        i_ready     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // words before any session start are dropped
        send_word(ACT_BYTE, 8'hFF);
        send_word(ACT_TICK, 8'h00);
        send_word(ACT_NONE, 8'h00);
        // refused security type: fail and terminate from one word, then a dead session
        open_session(1'b0, 8'h00);
        send_word(ACT_TICK, 8'hFF);

        for (int s = 0; s < 5; s++) begin
            case (s)
                0:       begin w = WIDTH_RESET; h = HEIGHT_RESET; end
                1:       begin w = 16'd1;       h = 16'd1;        end
                2:       begin w = 16'hFFFF;    h = 16'hFFFF;     end
                3:       begin w = 16'd1;       h = 16'hFFFF;     end
                default: begin
                    w = 16'($urandom_range(1, 65535));
                    h = 16'($urandom_range(1, 65535));
                end
            endcase
            settle();
            program_screen(w, h);
            no_idle          = (s == 2);
            phase_words      = 0;
            replies_at_start = sb.replies_made;
            while (phase_words < PHASE_WORDS ||
                   sb.replies_made - replies_at_start < PHASE_REPLIES)
                run_session();
        end
        no_idle = 1'b0;
        settle();

        if (sb.errors == 0)
            $display("rfb_server_message_parser_top verification clean");
        else
            $display("rfb_server_message_parser_top verification failed");
        $finish;
    end

endmodule
